[rtl/core/mmxq_pkg.sv]
// Shared constants, types and codes for the multiset max-xor query block.
package mmxq_pkg;

    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

endpackage

[rtl/core/mmxq_if.sv]
// Valid/ready channel interfaces for command and result beats.
interface mmxq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink (input valid, input command, input operand_value, output ready);
endinterface

interface mmxq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_xor;
    logic [1:0]  status;

    modport source (output valid, output max_xor, output status, input ready);
    modport sink (input valid, input max_xor, input status, output ready);
endinterface

[rtl/core/mmxq_cell.sv]
// One table entry of the rotating ring: a stored value and its occurrence count.
module mmxq_cell
    import mmxq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   seed,
    input  logic   shift,
    input  entry_t entry_in,
    output entry_t entry
);

    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.value <= '0;
            entry_reg.count <= COUNT_BITS'(seed);
        end
        else if (shift)
        begin
            entry_reg <= entry_in;
        end
    end

    assign entry = entry_reg;

endmodule

[rtl/core/mmxq_ctrl.sv]
// Sequencer at the head of the ring: matches, updates, scores or fills each passing entry.
module mmxq_ctrl
    import mmxq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mmxq_in_if.sink    in_ch,
    mmxq_out_if.source out_ch,
    input  entry_t head,
    output entry_t writeback,
    output logic   shift
);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [VALUE_BITS-1:0] opnd_reg;
    logic [IDX_BITS-1:0]   step_reg, step_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic                  hit_reg, hit_next;
    logic                  full_reg, full_next;
    logic                  out_valid_reg;
    logic [31:0]           max_xor_reg, max_xor_next;
    status_t               status_reg, status_next;

    logic                  live;
    logic                  match;
    logic                  last_step;
    logic [VALUE_BITS-1:0] xor_val;
    logic                  load_out;

    assign live      = (head.count != '0);
    assign match     = live && (head.value == opnd_reg);
    assign last_step = (step_reg == IDX_BITS'(CAPACITY - 1));
    assign xor_val   = head.value ^ opnd_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    // Per-entry update and scoring.
    always_comb
    begin
        writeback = head;
        best_next = best_reg;
        hit_next  = hit_reg;
        full_next = full_reg;
        step_next = last_step ? '0 : step_reg + 1'b1;
        case (state_reg)
            S_SCAN:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (match)
                        begin
                            hit_next = 1'b1;
                            if (head.count == COUNT_MAX)
                                full_next = 1'b1;
                            else
                                writeback.count = head.count + 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (match)
                        begin
                            hit_next        = 1'b1;
                            writeback.count = head.count - 1'b1;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (live)
                        begin
                            hit_next = 1'b1;
                            if (xor_val > best_reg)
                                best_next = xor_val;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PLACE:
            begin
                if (!live && !hit_reg)
                begin
                    writeback.value = opnd_reg;
                    writeback.count = COUNT_BITS'(1);
                    hit_next        = 1'b1;
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    // Result formation.
    always_comb
    begin
        max_xor_next = '0;
        status_next  = ST_OK;
        case (cmd_reg)
            CMD_INSERT: status_next = (full_reg || !hit_reg) ? ST_FULL : ST_OK;
            CMD_REMOVE: status_next = hit_reg ? ST_OK : ST_ABSENT;
            CMD_QUERY:  max_xor_next = 32'(hit_reg ? best_reg : opnd_reg);
            default:    status_next = ST_OK;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_step)
                    state_next = (cmd_reg == CMD_INSERT && !hit_next) ? S_PLACE : S_DONE;
            end
            S_PLACE:
            begin
                if (last_step)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ch.ready = 1'b0;
        shift       = 1'b0;
        case (state_reg)
            S_IDLE:  in_ch.ready = 1'b1;
            S_SCAN:  shift = 1'b1;
            S_PLACE: shift = 1'b1;
            default:
            begin
                in_ch.ready = 1'b0;
                shift       = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            hit_reg       <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (in_ch.valid && in_ch.ready)
            begin
                hit_reg  <= 1'b0;
                full_reg <= 1'b0;
            end
            else
            begin
                hit_reg  <= hit_next;
                full_reg <= full_next;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            cmd_reg  <= cmd_t'(in_ch.command);
            opnd_reg <= in_ch.operand_value[VALUE_BITS-1:0];
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
        if (load_out)
        begin
            max_xor_reg <= max_xor_next;
            status_reg  <= status_next;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.max_xor = max_xor_reg;
    assign out_ch.status  = status_reg;

endmodule

[rtl/core/multiset_max_xor_query.sv]
// Top level: a ring of CAPACITY entry cells rotating past one head sequencer.
// Each beat rotates the whole ring once before its result is loaded, and an insert of a
// new value takes a second rotation.
// One beat is in work at a time: a new beat is taken only once the last result has been
// loaded, and that waits until the result register is free to load.
// Asynchronous reset leaves the set holding the value zero once, in the first cell.
module multiset_max_xor_query
    import mmxq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mmxq_in_if.sink    in_ch,
    mmxq_out_if.source out_ch
);

    entry_t ring [CAPACITY];
    entry_t writeback;
    logic   shift;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t entry_in;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign entry_in = writeback;
        end
        else
        begin : g_link
            assign entry_in = ring[i+1];
        end

        mmxq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .seed     (i == 0),
            .shift    (shift),
            .entry_in (entry_in),
            .entry    (ring[i])
        );
    end

    mmxq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .head      (ring[0]),
        .writeback (writeback),
        .shift     (shift)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench for the multiset max-xor query block, with its own predictor.
module tb
    import mmxq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] operand;
    } command_beat_t;

    typedef struct {
        logic [31:0] max_xor;
        status_t     status;
    } result_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic steady = 1'b0;
    int   errors = 0;

    command_beat_t cmd_backlog[$];
    result_beat_t  awaited_results[$];

    logic [VALUE_BITS-1:0] set_value [CAPACITY];
    logic [COUNT_BITS-1:0] set_count [CAPACITY];
    int                    set_live;

    logic [31:0] key_pool[$];
    logic [31:0] fill_values[$];

    mmxq_in_if  cmd_ch ();
    mmxq_out_if res_ch ();

    multiset_max_xor_query uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void reset_model();
        int i;
        for (i = 0; i < CAPACITY; i++)
        begin
            set_value[i] = '0;
            set_count[i] = '0;
        end
        set_count[0] = COUNT_BITS'(1);
        set_live = 1;
    endfunction

    function automatic result_beat_t apply_command(input cmd_t cmd, input logic [31:0] operand);
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] best;
        int                    hit;
        int                    slot;
        int                    i;
        result_beat_t          r;
        v = operand[VALUE_BITS-1:0];
        r.max_xor = '0;
        r.status = ST_OK;
        hit = -1;
        slot = -1;
        for (i = 0; i < CAPACITY; i++)
        begin
            if (hit < 0 && set_count[i] != '0 && set_value[i] == v)
                hit = i;
            if (slot < 0 && set_count[i] == '0)
                slot = i;
        end
        case (cmd)
            CMD_INSERT:
            begin
                if (hit >= 0)
                begin
                    if (set_count[hit] >= COUNT_MAX)
                        r.status = ST_FULL;
                    else
                        set_count[hit] = set_count[hit] + 1'b1;
                end
                else if (slot >= 0)
                begin
                    set_value[slot] = v;
                    set_count[slot] = COUNT_BITS'(1);
                    set_live++;
                end
                else
                    r.status = ST_FULL;
            end
            CMD_REMOVE:
            begin
                if (hit < 0)
                    r.status = ST_ABSENT;
                else
                begin
                    set_count[hit] = set_count[hit] - 1'b1;
                    if (set_count[hit] == '0)
                        set_live--;
                end
            end
            CMD_QUERY:
            begin
                if (set_live == 0)
                    best = v;
                else
                begin
                    best = '0;
                    for (i = 0; i < CAPACITY; i++)
                        if (set_count[i] != '0 && (v ^ set_value[i]) > best)
                            best = v ^ set_value[i];
                end
                r.max_xor = 32'(best);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Driver: the prediction is made at the edge where the command beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.command <= CMD_NOP;
            cmd_ch.operand_value <= '0;
            reset_model();
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                awaited_results.push_back(apply_command(cmd_t'(cmd_ch.command),
                                                        cmd_ch.operand_value));
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() > 0 && (steady || $urandom_range(99) >= 9))
                begin
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.command <= cmd_backlog[0].cmd;
                    cmd_ch.operand_value <= cmd_backlog[0].operand;
                    void'(cmd_backlog.pop_front());
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("unexpected result max_xor=%h status=%0d",
                                              res_ch.max_xor, res_ch.status));
                else
                begin
                    if (res_ch.max_xor !== awaited_results[0].max_xor)
                        report_mismatch($sformatf("max_xor %h, predicted %h",
                                                  res_ch.max_xor, awaited_results[0].max_xor));
                    if (res_ch.status !== awaited_results[0].status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  res_ch.status, awaited_results[0].status));
                    void'(awaited_results.pop_front());
                end
            end
            res_ch.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    task automatic push_command(input cmd_t cmd, input logic [31:0] operand);
        command_beat_t b;
        b.cmd = cmd;
        b.operand = operand;
        cmd_backlog.push_back(b);
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_ch.valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_word();
        int pick;
        pick = $urandom_range(7);
        case (pick)
            0: return '1;
            1: return '0;
            2: return 32'd1 << $urandom_range(31);
            3: return ~(32'd1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic mixed_traffic(input int count);
        int          r;
        int          n;
        logic [31:0] v;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            v = key_pool[$urandom_range(key_pool.size() - 1)];
            if (r < 40)
                push_command(CMD_INSERT, v);
            else if (r < 70)
                push_command(CMD_REMOVE, ($urandom_range(4) == 0) ? $urandom : v);
            else if (r < 95)
                push_command(CMD_QUERY, ($urandom_range(1) == 0) ? random_word() : v);
            else
                push_command(CMD_NOP, $urandom);
        end
    endtask

    task automatic remove_random_fill();
        int idx;
        idx = $urandom_range(fill_values.size() - 1);
        push_command(CMD_REMOVE, fill_values[idx]);
        fill_values.delete(idx);
    endtask

    initial
    begin
        int          n;
        int          r;
        logic [31:0] v;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_command(CMD_QUERY, 32'h0000_0000);
        push_command(CMD_QUERY, 32'hFFFF_FFFF);
        push_command(CMD_INSERT, 32'hFFFF_FFFF);
        push_command(CMD_INSERT, 32'h0000_0000);
        push_command(CMD_QUERY, 32'h0000_0000);
        push_command(CMD_REMOVE, 32'h0000_0000);
        push_command(CMD_REMOVE, 32'h0000_0000);
        push_command(CMD_REMOVE, 32'h0000_0000);
        push_command(CMD_REMOVE, 32'h1234_5678);
        push_command(CMD_QUERY, 32'h0000_FFFF);
        push_command(CMD_REMOVE, 32'hFFFF_FFFF);
        push_command(CMD_QUERY, 32'hA5A5_A5A5);
        push_command(CMD_QUERY, 32'h0000_0000);
        push_command(CMD_REMOVE, 32'h0000_0000);
        push_command(CMD_NOP, 32'hFFFF_FFFF);
        push_command(CMD_NOP, 32'h0000_0000);
        push_command(CMD_INSERT, 32'h8000_0000);
        push_command(CMD_INSERT, 32'h0000_0001);
        push_command(CMD_INSERT, 32'h8000_0000);
        push_command(CMD_QUERY, 32'h0000_0001);
        push_command(CMD_REMOVE, 32'h8000_0000);
        push_command(CMD_QUERY, 32'h8000_0000);
        push_command(CMD_INSERT, 32'h0000_0000);
        push_command(CMD_QUERY, 32'hFFFF_FFFE);
        wait_drained();

        key_pool.push_back(32'h0000_0000);
        key_pool.push_back(32'hFFFF_FFFF);
        for (n = 0; n < 12; n++)
            key_pool.push_back(random_word());
        mixed_traffic(400);
        wait_drained();

        // Insert 252 random values toward capacity, with no idling on either side.
        steady = 1'b1;
        for (n = 0; n < 280; n++)
        begin
            if (n % 10 == 9)
                push_command(CMD_QUERY, $urandom);
            else
            begin
                v = $urandom;
                fill_values.push_back(v);
                push_command(CMD_INSERT, v);
            end
        end
        wait_drained();
        steady = 1'b0;

        for (n = 0; n < 200; n++)
        begin
            r = $urandom_range(99);
            if (r < 35 && fill_values.size() > 0)
                remove_random_fill();
            else if (r < 70)
            begin
                v = $urandom;
                fill_values.push_back(v);
                push_command(CMD_INSERT, v);
            end
            else
                push_command(CMD_QUERY, random_word());
        end
        while (fill_values.size() > 0)
            remove_random_fill();
        wait_drained();

        mixed_traffic(250);
        wait_drained();
        repeat (2 * CAPACITY + 8) @(posedge clk);

        if (errors == 0 && awaited_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
